/* hdl/lpr_pkg.sv */
// Shared widths, register indexes, item types, saturation bounds and rounding constants for the LPC residual block.
package lpr_pkg;

  localparam int SampW   = 16;              // PCM sample width
  localparam int MidW    = SampW + 1;       // left + right sum, twice the mid value
  localparam int CoefW   = 20;              // signed Q3.16 coefficient
  localparam int ProdW   = CoefW + MidW;    // one tap product
  localparam int MaxTaps = 4;
  localparam int AccW    = ProdW + $clog2(MaxTaps);
  localparam int FracW   = 17;              // Q3.16 times the half carried by the sum
  localparam int PredW   = 16;
  localparam int ResW    = 17;
  localparam int CfgIdxW = 2;

  // Configuration register map
  typedef enum logic [CfgIdxW-1:0] {
    REG_COEF_1,
    REG_COEF_2,
    REG_COEF_3,
    REG_COEF_4
  } reg_idx_e;

  // Saturation bounds and rounding offset in accumulator units
  localparam logic signed [AccW-1:0] AccHi     = AccW'(longint'(32767) << FracW);
  localparam logic signed [AccW-1:0] AccLo     = AccW'(-(longint'(32768) << FracW));
  localparam logic signed [AccW-1:0] RoundHalf = AccW'(longint'(1) << (FracW - 1));

  localparam logic signed [PredW-1:0] PredMax = 16'sh7FFF;
  localparam logic signed [PredW-1:0] PredMin = 16'sh8000;

  // Register write as seen by every cell
  typedef struct packed {
    logic                     we;
    logic [CfgIdxW-1:0]       idx;
    logic signed [CoefW-1:0]  data;
  } cfg_wr_t;

  // Per-request side data that travels down the cell chain with the partial sum
  typedef struct packed {
    logic                     valid;
    logic                     warm;       // still in warm-up, use warm_pred
    logic signed [PredW-1:0]  warm_pred;  // mid value rounded half up
    logic signed [MidW-1:0]   tmid;       // mid value truncated toward zero
  } item_ctl_t;

endpackage

/* hdl/lpr_in_if.sv */
// Input channel: one stereo sample pair and a restart flag per request.
interface lpr_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [lpr_pkg::SampW-1:0] left_sample;
  logic signed [lpr_pkg::SampW-1:0] right_sample;
  logic                             restart;

  modport source (output valid, left_sample, right_sample, restart, input ready);
  modport sink   (input valid, left_sample, right_sample, restart, output ready);
endinterface

/* hdl/lpr_out_if.sv */
// Output channel: residual, prediction and saturation flag per request.
interface lpr_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [lpr_pkg::ResW-1:0]  residual;
  logic signed [lpr_pkg::PredW-1:0] prediction;
  logic                             clipped;

  modport source (output valid, residual, prediction, clipped, input ready);
  modport sink   (input valid, residual, prediction, clipped, output ready);
endinterface

/* hdl/lpr_cell.sv */
// One tap cell: history entry, coefficient, skew line, multiplier and partial-sum adder.
module lpr_cell #(
  parameter int CellIdx = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lpr_pkg::cfg_wr_t                 cfg_i,
  input  logic                             adv_i,
  input  logic                             push_i,
  input  logic                             clear_i,
  input  logic signed [lpr_pkg::MidW-1:0]  tap_i,
  output logic signed [lpr_pkg::MidW-1:0]  tap_o,
  input  logic signed [lpr_pkg::AccW-1:0]  part_i,
  output logic signed [lpr_pkg::AccW-1:0]  part_o,
  input  lpr_pkg::item_ctl_t               ctl_i,
  output lpr_pkg::item_ctl_t               ctl_o
);
  import lpr_pkg::*;

  localparam logic [CfgIdxW-1:0] RegIdx = CfgIdxW'(int'(REG_COEF_1) + CellIdx - 1);

  logic signed [CoefW-1:0] coef_q;
  logic signed [MidW-1:0]  hist_q;
  logic signed [MidW-1:0]  mul_in;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [AccW-1:0]  part_d, part_q;
  item_ctl_t               ctl_q;

  // Hold this tap's coefficient
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_i.we && cfg_i.idx == RegIdx) begin
      coef_q <= cfg_i.data;
    end
  end

  // Shift history on each accepted request; restart zeroes the value seen by this request
  assign tap_o = clear_i ? '0 : hist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (push_i) begin
      hist_q <= tap_i;
    end
  end

  // Delay the tap value so its product meets the partial sum of the same request
  if (CellIdx == 1) begin : g_noskew
    assign mul_in = tap_o;
  end else begin : g_skew
    logic signed [MidW-1:0] skew_q [CellIdx-1];

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        skew_q[0] <= tap_o;
        for (int i = 1; i < CellIdx - 1; i++) begin
          skew_q[i] <= skew_q[i-1];
        end
      end
    end

    assign mul_in = skew_q[CellIdx-2];
  end

  // Multiply, then add to the neighbor's partial sum one stage later
  assign prod_d = ProdW'(coef_q) * ProdW'(mul_in);
  assign part_d = part_i + AccW'(prod_q);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
      part_q <= part_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  assign part_o = part_q;
  assign ctl_o  = ctl_q;

endmodule

/* hdl/lpr_out.sv */
// Output stage: take the warm-up prediction or saturate and round the sum, form the residual, hold the result.
module lpr_out (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic signed [lpr_pkg::AccW-1:0]  part_i,
  input  lpr_pkg::item_ctl_t               ctl_i,
  output logic                             adv_o,
  lpr_out_if.source                        res_o
);
  import lpr_pkg::*;

  logic signed [AccW-1:0]  rnd;
  logic signed [PredW-1:0] pred_d;
  logic                    clip_d;
  logic signed [ResW:0]    diff;

  logic                    vld_q;
  logic signed [PredW-1:0] pred_q;
  logic                    clip_q;
  logic signed [ResW-1:0]  res_q;

  // Saturate on the exact accumulator, otherwise round half up
  assign rnd = part_i + RoundHalf;

  always_comb begin
    pred_d = rnd[FracW+PredW-1:FracW];
    clip_d = 1'b0;
    if (ctl_i.warm) begin
      pred_d = ctl_i.warm_pred;
    end else if (part_i > AccHi) begin
      pred_d = PredMax;
      clip_d = 1'b1;
    end else if (part_i < AccLo) begin
      pred_d = PredMin;
      clip_d = 1'b1;
    end
  end

  assign diff = (ResW+1)'(ctl_i.tmid) - (ResW+1)'(pred_d);

  // Advance whenever the output register is empty or being drained
  assign adv_o = !vld_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_o) begin
      vld_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && ctl_i.valid) begin
      pred_q <= pred_d;
      clip_q <= clip_d;
      res_q  <= diff[ResW-1:0];
    end
  end

  assign res_o.valid      = vld_q;
  assign res_o.prediction = pred_q;
  assign res_o.clipped    = clip_q;
  assign res_o.residual   = res_q;

  // A saturated prediction sits on one of the two bounds
  a_clip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.clipped |-> res_o.prediction == PredMax ||
                                     res_o.prediction == PredMin)
    else $error("clipped prediction is not a bound");

  // Warm-up requests never report saturation
  a_warm_noclip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_o && ctl_i.valid && ctl_i.warm |=> !res_o.clipped)
    else $error("warm-up request reported as clipped");

endmodule

/* hdl/linear_prediction_residual.sv */
// Top level of the linear-prediction residual block over the stereo mid value.
//
// Each request carries one left/right sample pair; the block predicts the mid value from the
// ORDER previous mid values with signed Q3.16 coefficients (registers 0..3, 65536 = 1.0),
// saturates and rounds the prediction, and returns it with the residual and a clip flag.
// A new pair is taken every clock cycle unless a result waits at the output; each result
// passes the first cell's product register, the partial-sum registers of the ORDER cells
// and the output register. The first ORDER pairs after reset or restart predict the mid
// value itself. Write coefficients only with no request in flight; the block does not enforce it.
module linear_prediction_residual #(
  parameter int ORDER = 3  // number of taps, 1 to 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lpr_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic signed [lpr_pkg::CoefW-1:0]   cfg_data_i,
  lpr_in_if.sink                             src_i,
  lpr_out_if.source                          res_o
);
  import lpr_pkg::*;

  localparam int CntW = $clog2(ORDER + 1);

  cfg_wr_t                 cfg_wr;
  logic                    adv;
  logic                    push;
  logic signed [MidW-1:0]  s_sum;
  logic signed [MidW:0]    s_ext, s_up, s_trunc;
  logic [CntW-1:0]         cnt_q, cnt_eff;
  logic                    warm;
  item_ctl_t               ctl_s0_q;

  logic signed [MidW-1:0]  tap  [ORDER];
  logic signed [AccW-1:0]  part [ORDER+1];
  item_ctl_t               ctl  [ORDER+1];

  assign cfg_wr = '{we: cfg_we_i, idx: cfg_idx_i, data: cfg_data_i};

  // Accept a request whenever the chain advances
  assign src_i.ready = adv;
  assign push        = src_i.valid && adv;

  // Form the sum, the rounded mid and the truncated mid
  assign s_sum   = MidW'(src_i.left_sample) + MidW'(src_i.right_sample);
  assign s_ext   = (MidW+1)'(s_sum);
  assign s_up    = s_ext + (MidW+1)'(1);
  assign s_trunc = s_ext + {{MidW{1'b0}}, s_sum[MidW-1]};

  // Count warm-up samples since restart, saturating at ORDER
  assign cnt_eff = src_i.restart ? '0 : cnt_q;
  assign warm    = cnt_eff < CntW'(ORDER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (push) begin
      cnt_q <= warm ? cnt_eff + CntW'(1) : cnt_eff;
    end
  end

  // Register side data so it meets the first cell's product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s0_q <= '0;
    end else if (adv) begin
      ctl_s0_q <= '{valid: push, warm: warm, warm_pred: s_up[PredW:1],
                    tmid: s_trunc[MidW:1]};
    end
  end

  assign tap[0]  = s_sum;
  assign part[0] = '0;
  assign ctl[0]  = ctl_s0_q;

  // Row of tap cells: history shifts one way, partial sums the same way
  for (genvar g = 0; g < ORDER; g++) begin : g_cell
    if (g == ORDER - 1) begin : g_last
      lpr_cell #(.CellIdx(g + 1)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .cfg_i   (cfg_wr),
        .adv_i   (adv),
        .push_i  (push),
        .clear_i (src_i.restart),
        .tap_i   (tap[g]),
        .tap_o   (),
        .part_i  (part[g]),
        .part_o  (part[g+1]),
        .ctl_i   (ctl[g]),
        .ctl_o   (ctl[g+1])
      );
    end else begin : g_mid
      lpr_cell #(.CellIdx(g + 1)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .cfg_i   (cfg_wr),
        .adv_i   (adv),
        .push_i  (push),
        .clear_i (src_i.restart),
        .tap_i   (tap[g]),
        .tap_o   (tap[g+1]),
        .part_i  (part[g]),
        .part_o  (part[g+1]),
        .ctl_i   (ctl[g]),
        .ctl_o   (ctl[g+1])
      );
    end
  end

  lpr_out u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .part_i (part[ORDER]),
    .ctl_i  (ctl[ORDER]),
    .adv_o  (adv),
    .res_o  (res_o)
  );

  // Restart leaves exactly one sample counted
  a_restart_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && src_i.restart |=> cnt_q == CntW'(1))
    else $error("warm-up count wrong after restart");

  // Warm-up count never passes the tap count
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ORDER))
    else $error("warm-up count above order");

  // Input is held off only by a result waiting at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !src_i.ready |-> res_o.valid && !res_o.ready)
    else $error("input stalled without a waiting result");

endmodule

/* bench/tb_linear_prediction_residual.sv */
// Testbench for linear_prediction_residual: directed and random sample streams checked against a predictor.
module tb_linear_prediction_residual;
  import lpr_pkg::*;

  localparam int     Order       = 3;
  localparam int     StallLimit  = 4000;
  localparam int     ReportLimit = 10;
  localparam int     PhaseItems  = 56;
  localparam int     RandPhases  = 8;
  localparam longint SatHi       = longint'(32767) * 131072;
  localparam longint SatLo       = longint'(-32768) * 131072;

  localparam logic signed [CoefW-1:0] CoefMax  = 20'sh7FFFF;
  localparam logic signed [CoefW-1:0] CoefMin  = 20'sh80000;
  localparam logic signed [CoefW-1:0] CoefOne  = 20'sh10000;
  localparam logic signed [CoefW-1:0] CoefZero = 20'sh00000;
  localparam logic signed [SampW-1:0] SampMax  = 16'sh7FFF;
  localparam logic signed [SampW-1:0] SampMin  = 16'sh8000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
  typedef enum int {COEF_MILD, COEF_EXTREME, COEF_RANDOM} coef_style_e;

  typedef struct packed {
    logic signed [ResW-1:0]  residual;
    logic signed [PredW-1:0] prediction;
    logic                    clipped;
  } lpc_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic signed [CoefW-1:0] cfg_data_i;

  lpr_in_if  in_ch ();
  lpr_out_if out_ch ();

  linear_prediction_residual #(
    .ORDER(Order)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .src_i     (in_ch),
    .res_o     (out_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: coefficient copy, past sums (twice the mid), warm-up count
  logic signed [CoefW-1:0] coef_q [MaxTaps];
  logic signed [MidW-1:0]  sum_hist [MaxTaps];
  int                      warm_count;

  lpc_result_t expected_residuals [$];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          mismatches;
  int          stalled_cycles;

  // Compute the result of one sample pair and advance the history
  function automatic lpc_result_t predict_residual(input logic signed [SampW-1:0] l,
                                                   input logic signed [SampW-1:0] r,
                                                   input logic restart);
    lpc_result_t res;
    int          sum;
    int          tmid;
    int          pred;
    int          j;
    longint      acc;
    sum = int'(l) + int'(r);
    tmid = sum / 2;
    res.clipped = 1'b0;
    if (restart) begin
      for (j = 0; j < MaxTaps; j++) sum_hist[j] = '0;
      warm_count = 0;
    end
    if (warm_count < Order) begin
      // warm-up: mid value rounded half up
      pred = (sum + 1) >>> 1;
    end else begin
      acc = 0;
      for (j = 0; j < Order; j++) acc += longint'(coef_q[j]) * longint'(sum_hist[j]);
      if (acc > SatHi) begin
        pred = 32767;
        res.clipped = 1'b1;
      end else if (acc < SatLo) begin
        pred = -32768;
        res.clipped = 1'b1;
      end else begin
        pred = int'((acc + 65536) >>> 17);
      end
    end
    for (j = MaxTaps - 1; j > 0; j--) sum_hist[j] = sum_hist[j-1];
    sum_hist[0] = sum[MidW-1:0];
    if (warm_count < Order) warm_count++;
    res.residual = ResW'(tmid - pred);
    res.prediction = PredW'(pred);
    return res;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= ReportLimit) $display("%s", msg);
  endtask

  // Send one request; called at a falling edge, returns at a falling edge
  task automatic send_pair(input logic signed [SampW-1:0] l, input logic signed [SampW-1:0] r,
                           input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.left_sample  <= l;
    in_ch.right_sample <= r;
    in_ch.restart      <= restart;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_residuals.insert(expected_residuals.size(), predict_residual(l, r, restart));
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_residuals.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic signed [CoefW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    coef_q[idx] = value;
    @(negedge clk_i);
  endtask

  task automatic set_coefs(input logic signed [CoefW-1:0] c1, input logic signed [CoefW-1:0] c2,
                           input logic signed [CoefW-1:0] c3, input logic signed [CoefW-1:0] c4);
    write_reg(REG_COEF_1, c1);
    write_reg(REG_COEF_2, c2);
    write_reg(REG_COEF_3, c3);
    write_reg(REG_COEF_4, c4);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idle(input idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 54 : (mode == IDLE_BOTH) ? 13 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 54 : (mode == IDLE_BOTH) ? 13 : 0;
  endtask

  function automatic logic signed [CoefW-1:0] pick_coef(input coef_style_e style);
    int unsigned r;
    int          v;
    r = $urandom;
    case (style)
      COEF_MILD: begin
        v = int'($urandom_range(0, 131072)) - 65536;
        return v[CoefW-1:0];
      end
      COEF_EXTREME: begin
        case ($urandom_range(4))
          0: return CoefMax;
          1: return CoefMin;
          2: return CoefOne;
          3: return -CoefOne;
          default: return CoefZero;
        endcase
      end
      default: return r[CoefW-1:0];
    endcase
  endfunction

  function automatic logic signed [SampW-1:0] pick_sample(input int kind);
    int unsigned r;
    int          v;
    r = $urandom;
    v = int'($urandom_range(0, 600)) - 300;
    case (kind)
      0: return r[SampW-1:0];
      1: begin
        case ($urandom_range(3))
          0: return SampMax;
          1: return SampMin;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return v[SampW-1:0];
    endcase
  endfunction

  // Warm-up at the sample extremes, zero weights, and a restart mid-stream
  task automatic test_warmup_and_restart();
    set_idle(IDLE_NONE);
    send_pair(SampMax, SampMax, 1'b0);
    send_pair(SampMin, SampMin, 1'b0);
    send_pair(SampMax, SampMin, 1'b0);
    send_pair(16'sd0, 16'sd1, 1'b0);
    send_pair(SampMin, -16'sd32767, 1'b0);
    send_pair(SampMax, SampMax, 1'b0);
    send_pair(SampMin, SampMin, 1'b0);
    send_pair(-16'sd1, 16'sd0, 1'b1);
    send_pair(16'sd1, 16'sd0, 1'b0);
    send_pair(-16'sd2, -16'sd1, 1'b0);
    wait_drained();
  endtask

  // Unit weight: exact saturation bounds stay unclipped, halves round up; tap four ignored
  task automatic test_rounding_bounds();
    set_coefs(CoefOne, CoefZero, CoefZero, CoefMax);
    send_pair(SampMax, SampMax, 1'b1);
    repeat (3) send_pair(SampMax, SampMax, 1'b0);
    repeat (2) send_pair(SampMin, SampMin, 1'b0);
    send_pair(16'sd0, 16'sd1, 1'b0);
    send_pair(16'sd0, 16'sd0, 1'b0);
    send_pair(16'sd0, -16'sd1, 1'b0);
    send_pair(16'sd0, 16'sd0, 1'b0);
    wait_drained();
  endtask

  // Extreme weights drive the prediction into both saturation bounds
  task automatic test_saturation();
    set_coefs(CoefMax, CoefMin, CoefMax, CoefMin);
    send_pair(SampMax, SampMax, 1'b1);
    send_pair(SampMin, SampMin, 1'b0);
    send_pair(SampMax, SampMax, 1'b0);
    repeat (3) send_pair(16'sd0, 16'sd0, 1'b0);
    wait_drained();
  endtask

  // Random stream under one idling pattern and one coefficient setting
  task automatic test_random_stream(input idle_mode_e mode, input coef_style_e style);
    int kind;
    set_coefs(pick_coef(style), pick_coef(style), pick_coef(style), pick_coef(style));
    set_idle(mode);
    repeat (PhaseItems) begin
      kind = $urandom_range(2);
      send_pair(pick_sample(kind), pick_sample(kind), $urandom_range(99) < 4);
    end
    wait_drained();
  endtask

  // Randomize output backpressure
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    lpc_result_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_residuals.size() == 0) begin
        flag_error($sformatf("unexpected result: res=%0d pred=%0d clip=%0b",
                             out_ch.residual, out_ch.prediction, out_ch.clipped));
      end else begin
        want = expected_residuals.pop_front();
        if (out_ch.residual !== want.residual || out_ch.prediction !== want.prediction ||
            out_ch.clipped !== want.clipped) begin
          flag_error($sformatf("mismatch: expected res=%0d pred=%0d clip=%0b, got res=%0d pred=%0d clip=%0b",
                               want.residual, want.prediction, want.clipped,
                               out_ch.residual, out_ch.prediction, out_ch.clipped));
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin : run_tests
    int phase;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_COEF_1;
    cfg_data_i         = '0;
    in_ch.valid        = 1'b0;
    in_ch.left_sample  = '0;
    in_ch.right_sample = '0;
    in_ch.restart      = 1'b0;
    out_ch.ready       = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    mismatches         = 0;
    stalled_cycles     = 0;
    warm_count         = 0;
    for (phase = 0; phase < MaxTaps; phase++) begin
      coef_q[phase]   = '0;
      sum_hist[phase] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_warmup_and_restart();
    test_rounding_bounds();
    test_saturation();
    for (phase = 0; phase < RandPhases; phase++) begin
      test_random_stream(idle_mode_e'(phase % 4), coef_style_e'(phase % 3));
    end

    // Let any stray result surface
    repeat (Order + 8) @(posedge clk_i);
    if (mismatches == 0 && expected_residuals.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
